// ===== rtl/fra_pkg.sv =====
// Shared types and constants of the first-fit range allocator.
package fra_pkg;

  // Fixed field widths of the ports
  localparam int unsigned FIELD_ADDR_W = 16;
  localparam int unsigned SIZE_W       = 17;
  localparam int unsigned CMD_W        = 2;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_REINIT = 2'd2
  } cmd_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_SHDN = 4'b0100,
    S_SHUP = 4'b1000
  } state_t;

  // Compare results of the shared unit for one table entry
  typedef struct packed {
    logic fit;          // request size fits in the entry
    logic exact;        // request size equals the entry length
    logic below;        // block address lies below the entry start
    logic touch_lo;     // entry ends just before the block
    logic touch_hi;     // block ends just before the entry
    logic at_or_after;  // entry end is at or below the block address
  } cmp_flags_t;

endpackage

// ===== rtl/fra_table.sv =====
// Free-range table memory with a fresh-table flag standing in for entry 0.
module fra_table #(
  parameter int unsigned ADDR_BITS  = 16,
  parameter int unsigned MAX_RANGES = 32,
  localparam int unsigned IDX_W     = $clog2(MAX_RANGES),
  localparam int unsigned ENT_W     = 2 * ADDR_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 init,
  input  logic [ADDR_BITS-1:0] top,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [ENT_W-1:0]     rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [ENT_W-1:0]     wr_data
);

  logic [ENT_W-1:0] mem [MAX_RANGES];
  logic [ENT_W-1:0] rd_q;
  logic             fresh;
  logic             rd_fresh;

  // Write and read the entries, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Track whether entry 0 still holds the single full range
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh    <= 1'b1;
      rd_fresh <= 1'b0;
    end else begin
      if (init) begin
        fresh <= 1'b1;
      end else if (wr_en && (wr_addr == '0)) begin
        fresh <= 1'b0;
      end
      if (rd_en) begin
        rd_fresh <= fresh && (rd_addr == '0);
      end
    end
  end

  // Substitute the full range while entry 0 is unwritten
  assign rd_data = rd_fresh ? {ADDR_BITS'(0), top} : rd_q;

endmodule

// ===== rtl/fra_alu.sv =====
// Shared compare and add unit applied to one table entry per cycle.
module fra_alu #(
  parameter int unsigned ADDR_BITS = 16,
  localparam int unsigned ENT_W    = 2 * ADDR_BITS,
  localparam int unsigned AW1      = ADDR_BITS + 1,
  localparam int unsigned LW       = (AW1 > fra_pkg::SIZE_W) ? AW1 : fra_pkg::SIZE_W
) (
  input  logic [ENT_W-1:0]            ent,
  input  logic [fra_pkg::SIZE_W-1:0]  size,
  input  logic [ADDR_BITS-1:0]        ad,
  input  logic [ADDR_BITS-1:0]        e,
  output fra_pkg::cmp_flags_t         flags,
  output logic [ADDR_BITS-1:0]        new_start
);

  logic [ADDR_BITS-1:0] s;
  logic [ADDR_BITS-1:0] en;
  logic [LW-1:0]        len;
  logic [LW-1:0]        sz;
  logic [LW-1:0]        sum;

  assign s  = ent[ENT_W-1:ADDR_BITS];
  assign en = ent[ADDR_BITS-1:0];

  // Entry length and request size at a common width
  assign len = LW'(en) - LW'(s) + LW'(1);
  assign sz  = LW'(size);
  assign sum = LW'(s) + sz;

  // Compare the entry against the pending request
  always_comb begin
    flags.fit         = sz <= len;
    flags.exact       = sz == len;
    flags.below       = ad < s;
    flags.touch_lo    = (AW1'(en) + AW1'(1)) == AW1'(ad);
    flags.touch_hi    = (AW1'(e) + AW1'(1)) == AW1'(s);
    flags.at_or_after = en <= ad;
  end

  assign new_start = sum[ADDR_BITS-1:0];

endmodule

// ===== rtl/first_fit_range_allocator_unit.sv =====
// Top level of the first-fit range allocator: command sequencer around table and compare unit.
//
//   Channel  Signals                              Direction  Transaction when
//   command  start, busy, command, size, address  in         start && !busy
//   result   done, address_res, ok                out        done (one cycle, no stall)
//   config   cfg_valid, cfg_ready, memory_top     in         cfg_valid && cfg_ready
//
// Reinitialise, unknown commands, zero-length or overrunning frees and any request on an
// empty table finish in the cycle after start. Allocate and free otherwise stream the table
// through one read port, one entry a cycle, until a hit or the last entry ends the scan; a
// removal or insertion then moves each later entry by one place.
// Reset leaves the block idle at once; entry 0 reads as [0, memory_top] until written.
// Results cannot be held off by the receiver; busy stays high until done is driven.
module first_fit_range_allocator_unit #(
  parameter int unsigned MAX_RANGES = 32,
  parameter int unsigned ADDR_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [fra_pkg::CMD_W-1:0]        command,
  input  logic [fra_pkg::SIZE_W-1:0]       size,
  input  logic [fra_pkg::FIELD_ADDR_W-1:0] address,
  output logic                             done,
  output logic [fra_pkg::FIELD_ADDR_W-1:0] address_res,
  output logic                             ok,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fra_pkg::FIELD_ADDR_W-1:0] memory_top
);

  localparam int unsigned IDX_W = $clog2(MAX_RANGES);
  localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);
  localparam int unsigned ENT_W = 2 * ADDR_BITS;
  localparam int unsigned EW    =
      ((ADDR_BITS > fra_pkg::SIZE_W) ? ADDR_BITS : fra_pkg::SIZE_W) + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RANGES);

  // Control registers
  fra_pkg::state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             dv, dv_next;
  logic             rd_active, rd_active_next;
  logic [fra_pkg::FIELD_ADDR_W-1:0] mem_top, mem_top_next;
  logic             done_next;

  // Payload and pointer registers
  logic                       is_alloc, is_alloc_next;
  logic [fra_pkg::SIZE_W-1:0] size_q, size_next;
  logic [ADDR_BITS-1:0]       ad_q, ad_next;
  logic [ADDR_BITS-1:0]       e_q, e_next;
  logic [ADDR_BITS-1:0]       gnt, gnt_next;
  logic [CNT_W-1:0]           rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]           wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0]           cmp_idx, cmp_idx_next;
  logic [CNT_W-1:0]           stop_idx, stop_idx_next;
  logic [ENT_W-1:0]           prev_ent, prev_ent_next;
  logic                       prev_touch, prev_touch_next;
  logic                       ok_next;
  logic [fra_pkg::FIELD_ADDR_W-1:0] address_res_next;

  // Table and compare unit connections
  logic                 tbl_init;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [ENT_W-1:0]     rd_data;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [ENT_W-1:0]     wr_data;
  fra_pkg::cmp_flags_t  flags;
  logic [ADDR_BITS-1:0] new_start;

  // Request decode
  fra_pkg::cmd_t        cmd_in;
  logic [ADDR_BITS-1:0] ad_in;
  logic [EW-1:0]        e_wide;
  logic [ADDR_BITS-1:0] e_in;
  logic                 e_ovf;
  logic                 size_zero;
  logic [ADDR_BITS-1:0] top_addr;
  logic [ADDR_BITS-1:0] cur_start;
  logic [ADDR_BITS-1:0] cur_end;
  logic [ADDR_BITS-1:0] prev_start;
  logic [CNT_W-1:0]     cmp_prev;
  logic                 hit;
  logic                 last;
  logic                 issue;
  logic                 fin;
  logic                 fin_ok;
  logic                 merge_l;
  logic                 merge_r;

  assign cmd_in    = fra_pkg::cmd_t'(command);
  assign ad_in     = ADDR_BITS'(address);
  assign e_wide    = EW'(ad_in) + EW'(size) - EW'(1);
  assign e_in      = e_wide[ADDR_BITS-1:0];
  assign e_ovf     = |e_wide[EW-1:ADDR_BITS];
  assign size_zero = size == '0;
  assign top_addr  = ADDR_BITS'(mem_top);

  assign cur_start  = rd_data[ENT_W-1:ADDR_BITS];
  assign cur_end    = rd_data[ADDR_BITS-1:0];
  assign prev_start = prev_ent[ENT_W-1:ADDR_BITS];
  assign cmp_prev   = cmp_idx - CNT_W'(1);
  assign hit        = dv && (is_alloc ? flags.fit : flags.below);
  assign last       = cmp_idx == (count - CNT_W'(1));
  assign merge_l    = (cmp_idx != '0) && prev_touch;
  assign merge_r    = flags.touch_hi;

  assign busy      = state != fra_pkg::S_IDLE;
  assign cfg_ready = (state == fra_pkg::S_IDLE) && !start;

  fra_table #(
    .ADDR_BITS  (ADDR_BITS),
    .MAX_RANGES (MAX_RANGES)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .init    (tbl_init),
    .top     (top_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  fra_alu #(
    .ADDR_BITS (ADDR_BITS)
  ) u_alu (
    .ent       (rd_data),
    .size      (size_q),
    .ad        (ad_q),
    .e         (e_q),
    .flags     (flags),
    .new_start (new_start)
  );

  // Sequence one transaction over the table
  always_comb begin
    state_next       = state;
    count_next       = count;
    dv_next          = 1'b0;
    rd_active_next   = rd_active;
    mem_top_next     = mem_top;
    done_next        = 1'b0;
    is_alloc_next    = is_alloc;
    size_next        = size_q;
    ad_next          = ad_q;
    e_next           = e_q;
    gnt_next         = gnt;
    rd_ptr_next      = rd_ptr;
    wr_ptr_next      = wr_ptr;
    cmp_idx_next     = cmp_idx;
    stop_idx_next    = stop_idx;
    prev_ent_next    = prev_ent;
    prev_touch_next  = prev_touch;
    ok_next          = ok;
    address_res_next = address_res;
    tbl_init         = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = rd_ptr[IDX_W-1:0];
    wr_en            = 1'b0;
    wr_addr          = '0;
    wr_data          = '0;
    issue            = 1'b0;
    fin              = 1'b0;
    fin_ok           = 1'b0;

    unique case (state)
      fra_pkg::S_IDLE: begin
        if (start) begin
          size_next     = size;
          ad_next       = ad_in;
          e_next        = e_in;
          is_alloc_next = cmd_in == fra_pkg::CMD_ALLOC;
          rd_ptr_next   = '0;
          cmp_idx_next  = '0;
          unique case (cmd_in)
            fra_pkg::CMD_ALLOC: begin
              if (count == '0) begin
                fin = 1'b1;
              end else begin
                state_next = fra_pkg::S_SCAN;
              end
            end
            fra_pkg::CMD_FREE: begin
              if (size_zero || e_ovf) begin
                fin = 1'b1;
              end else if (count == '0) begin
                // Block becomes the only range
                wr_en      = 1'b1;
                wr_data    = {ad_in, e_in};
                count_next = CNT_W'(1);
                fin        = 1'b1;
                fin_ok     = 1'b1;
              end else begin
                state_next = fra_pkg::S_SCAN;
              end
            end
            fra_pkg::CMD_REINIT: begin
              tbl_init   = 1'b1;
              count_next = CNT_W'(1);
              fin        = 1'b1;
              fin_ok     = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end else if (cfg_valid && cfg_ready) begin
          mem_top_next = memory_top;
          tbl_init     = 1'b1;
          count_next   = CNT_W'(1);
        end
      end

      fra_pkg::S_SCAN: begin
        // Stream reads one entry ahead of the compare
        issue = rd_ptr < count;
        if (issue) begin
          rd_en       = 1'b1;
          rd_ptr_next = rd_ptr + CNT_W'(1);
        end
        dv_next = issue;
        if (dv) begin
          cmp_idx_next    = cmp_idx + CNT_W'(1);
          prev_ent_next   = rd_data;
          prev_touch_next = flags.touch_lo;
          if (hit) begin
            dv_next = 1'b0;
            if (is_alloc) begin
              gnt_next = cur_start;
              if (!flags.exact) begin
                // Trim the front of the range
                wr_en   = 1'b1;
                wr_addr = cmp_idx[IDX_W-1:0];
                wr_data = {new_start, cur_end};
                fin     = 1'b1;
                fin_ok  = 1'b1;
              end else begin
                // Range used up: close the gap
                rd_ptr_next = cmp_idx + CNT_W'(1);
                wr_ptr_next = cmp_idx;
                state_next  = fra_pkg::S_SHDN;
              end
            end else if (count == CNT_MAX) begin
              fin = 1'b1;
            end else if (merge_l && merge_r) begin
              // Join previous range, block and this range
              wr_en       = 1'b1;
              wr_addr     = cmp_prev[IDX_W-1:0];
              wr_data     = {prev_start, cur_end};
              rd_ptr_next = cmp_idx + CNT_W'(1);
              wr_ptr_next = cmp_idx;
              state_next  = fra_pkg::S_SHDN;
            end else if (merge_l) begin
              wr_en   = 1'b1;
              wr_addr = cmp_prev[IDX_W-1:0];
              wr_data = {prev_start, e_q};
              fin     = 1'b1;
              fin_ok  = 1'b1;
            end else if (merge_r) begin
              wr_en   = 1'b1;
              wr_addr = cmp_idx[IDX_W-1:0];
              wr_data = {ad_q, cur_end};
              fin     = 1'b1;
              fin_ok  = 1'b1;
            end else begin
              // Open a slot at this entry
              rd_ptr_next    = count - CNT_W'(1);
              wr_ptr_next    = count;
              stop_idx_next  = cmp_idx;
              rd_active_next = 1'b1;
              state_next     = fra_pkg::S_SHUP;
            end
          end else if (last) begin
            if (is_alloc || !flags.at_or_after || (count == CNT_MAX)) begin
              fin = 1'b1;
            end else if (flags.touch_lo) begin
              // Extend the last range
              wr_en   = 1'b1;
              wr_addr = cmp_idx[IDX_W-1:0];
              wr_data = {cur_start, e_q};
              fin     = 1'b1;
              fin_ok  = 1'b1;
            end else begin
              // Append after the last range
              wr_en      = 1'b1;
              wr_addr    = count[IDX_W-1:0];
              wr_data    = {ad_q, e_q};
              count_next = count + CNT_W'(1);
              fin        = 1'b1;
              fin_ok     = 1'b1;
            end
          end
        end
      end

      fra_pkg::S_SHDN: begin
        // Move each later entry down by one
        issue = rd_ptr < count;
        if (issue) begin
          rd_en       = 1'b1;
          rd_ptr_next = rd_ptr + CNT_W'(1);
        end
        dv_next = issue;
        if (dv) begin
          wr_en       = 1'b1;
          wr_addr     = wr_ptr[IDX_W-1:0];
          wr_data     = rd_data;
          wr_ptr_next = wr_ptr + CNT_W'(1);
        end
        if (!issue && !dv) begin
          count_next = count - CNT_W'(1);
          fin        = 1'b1;
          fin_ok     = 1'b1;
        end
      end

      fra_pkg::S_SHUP: begin
        // Move entries up by one, last first
        issue = rd_active;
        if (issue) begin
          rd_en = 1'b1;
          if (rd_ptr == stop_idx) begin
            rd_active_next = 1'b0;
          end else begin
            rd_ptr_next = rd_ptr - CNT_W'(1);
          end
        end
        dv_next = issue;
        if (dv) begin
          wr_en       = 1'b1;
          wr_addr     = wr_ptr[IDX_W-1:0];
          wr_data     = rd_data;
          wr_ptr_next = wr_ptr - CNT_W'(1);
        end
        if (!issue && !dv) begin
          wr_en      = 1'b1;
          wr_addr    = stop_idx[IDX_W-1:0];
          wr_data    = {ad_q, e_q};
          count_next = count + CNT_W'(1);
          fin        = 1'b1;
          fin_ok     = 1'b1;
        end
      end

      default: begin
        state_next = fra_pkg::S_IDLE;
      end
    endcase

    // Drive the result for one cycle
    if (fin) begin
      state_next       = fra_pkg::S_IDLE;
      done_next        = 1'b1;
      ok_next          = fin_ok;
      address_res_next = (fin_ok && is_alloc_next) ?
                         fra_pkg::FIELD_ADDR_W'(gnt_next) : '0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fra_pkg::S_IDLE;
      count     <= CNT_W'(1);
      dv        <= 1'b0;
      rd_active <= 1'b0;
      mem_top   <= '1;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      dv        <= dv_next;
      rd_active <= rd_active_next;
      mem_top   <= mem_top_next;
      done      <= done_next;
    end
  end

  // Hold payload and pointers
  always_ff @(posedge clk) begin
    is_alloc    <= is_alloc_next;
    size_q      <= size_next;
    ad_q        <= ad_next;
    e_q         <= e_next;
    gnt         <= gnt_next;
    rd_ptr      <= rd_ptr_next;
    wr_ptr      <= wr_ptr_next;
    cmp_idx     <= cmp_idx_next;
    stop_idx    <= stop_idx_next;
    prev_ent    <= prev_ent_next;
    prev_touch  <= prev_touch_next;
    ok          <= ok_next;
    address_res <= address_res_next;
  end

  // Table reads never collide with a write to the same entry
  assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("table read and write hit the same entry");

  // Range count stays within the table
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("range count beyond table size");

  // A result only follows work in progress or an accepted command
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result strobe without a transaction");

  // The range count changes only through a transaction or a configuration write
  assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> $past(busy || start || cfg_valid))
    else $error("range count changed while idle");

endmodule
